@@ rtl/core/telemetry_frame_scheduler_top_macros.svh @@
// Assertion macros shared by the telemetry frame scheduler RTL.
// Expects signals named clock and reset in the including module.
`ifndef TELEMETRY_FRAME_SCHEDULER_TOP_MACROS_SVH
`define TELEMETRY_FRAME_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TFS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define TFS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define TFS_ASSERT(lbl, prop, msg)
`define TFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/tfs_pkg.sv @@
// Types and constants for the telemetry frame scheduler.
// No dependencies; imported by every module of the block.
package tfs_pkg;

   localparam logic [1:0] KIND_MS_TICK  = 2'd0;
   localparam logic [1:0] KIND_SEC_TICK = 2'd1;
   localparam logic [1:0] KIND_SEND_NOW = 2'd2;
   localparam logic [1:0] KIND_TX_DONE  = 2'd3;

   localparam logic [2:0] PS_LOW       = 3'd4;
   localparam logic [2:0] PS_CRITICAL  = 3'd5;
   localparam logic [2:0] PS_HIBERNATE = 3'd6;
   localparam logic [2:0] PS_ERROR     = 3'd7;

   localparam logic [1:0] REG_INTERVAL_NORMAL    = 2'd0;
   localparam logic [1:0] REG_INTERVAL_LOW_POWER = 2'd1;
   localparam logic [1:0] REG_INTERVAL_CRITICAL  = 2'd2;

   localparam logic [15:0] INTERVAL_NORMAL_RESET    = 16'd5000;
   localparam logic [15:0] INTERVAL_LOW_POWER_RESET = 16'd10000;
   localparam logic [15:0] INTERVAL_CRITICAL_RESET  = 16'd30000;

   localparam logic [7:0] SYNC_BYTE_0 = 8'hAA;
   localparam logic [7:0] SYNC_BYTE_1 = 8'h55;
   localparam logic [7:0] STOP_BYTE   = 8'hFF;

   localparam logic [3:0] FRAME_LAST = 4'd15;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  pkt_id;
      logic [2:0]  power_state;
      logic [6:0]  charge_percent;
      logic [1:0]  boot_cause;
      logic [15:0] battery_centivolts;
      logic [15:0] solar_centivolts;
      logic [2:0]  status_bits;
      logic [2:0]  load_bits;
      logic [15:0] uptime;
      logic [7:0]  checksum;
   } frame_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_SEND = 2'b10
   } back_state_type;

endpackage

@@ rtl/core/telemetry_frame_scheduler_top.sv @@
// Telemetry frame scheduler, top level. Uses tfs_pkg, tfs_front, tfs_queue, tfs_back.
// Requests are taken one per cycle while the descriptor queue has room; a frame's
// first byte is valid once its descriptor has passed the queue and the back-end
// register, then one byte per cycle while rsp_tready is high. The byte serializer
// pops the next queued frame as the last byte of a frame is accepted. Synchronous
// active-high reset clears counters, busy flag and queue and loads interval defaults.
module telemetry_frame_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // power_state[2:0], charge_percent[9:3], boot_cause[11:10],
   // battery_centivolts[27:12], solar_centivolts[43:28], status_bits[46:44],
   // load_bits[49:47], zero fill [55:50]
   input  logic [55:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import tfs_pkg::*;

   logic           req_fire;
   logic           push;
   logic           pop;
   frame_desc_type push_desc;
   frame_desc_type head_desc;
   queue_stat_type stat;

   assign req_tready = !stat.full;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   tfs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_fire           (req_fire),
      .kind               (req_tuser),
      .power_state        (req_tdata[2:0]),
      .charge_percent     (req_tdata[9:3]),
      .boot_cause         (req_tdata[11:10]),
      .battery_centivolts (req_tdata[27:12]),
      .solar_centivolts   (req_tdata[43:28]),
      .status_bits        (req_tdata[46:44]),
      .load_bits          (req_tdata[49:47]),
      .csr_fire           (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .push               (push),
      .push_desc          (push_desc)
   );

   tfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .stat      (stat)
   );

   tfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_desc  (head_desc),
      .stat       (stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/core/tfs_queue.sv @@
// Two-entry queue of frame descriptors between front and back.
// Depends on tfs_pkg.
`include "telemetry_frame_scheduler_top_macros.svh"

module tfs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tfs_pkg::frame_desc_type push_desc,
   input  logic                    pop,
   output tfs_pkg::frame_desc_type head_desc,
   output tfs_pkg::queue_stat_type stat
);
   import tfs_pkg::*;

   frame_desc_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]     count_ff, count_in;

   localparam logic [QUEUE_CW-1:0] CountFull = QUEUE_CW'(QUEUE_DEPTH);
   localparam logic [QUEUE_AW-1:0] PtrLast   = QUEUE_AW'(QUEUE_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head_desc  = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CountFull);
   assign stat.empty = (count_ff == '0);

   `TFS_ASSERT(a_count_bound, count_ff <= CountFull, "queue count above depth")
   `TFS_ASSERT(a_no_pop_empty, pop |-> count_ff != '0, "pop from empty queue")
   `TFS_ASSERT(a_no_push_full, push |-> (count_ff != CountFull) || pop, "push into full queue")

endmodule

@@ rtl/core/tfs_front.sv @@
// Front end: takes request transactions, keeps timing state and config,
// decides when a frame goes out and builds its descriptor. Depends on tfs_pkg.
`include "telemetry_frame_scheduler_top_macros.svh"

module tfs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  logic [1:0]              kind,
   input  logic [2:0]              power_state,
   input  logic [6:0]              charge_percent,
   input  logic [1:0]              boot_cause,
   input  logic [15:0]             battery_centivolts,
   input  logic [15:0]             solar_centivolts,
   input  logic [2:0]              status_bits,
   input  logic [2:0]              load_bits,
   input  logic                    csr_fire,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_data,
   output logic                    push,
   output tfs_pkg::frame_desc_type push_desc
);
   import tfs_pkg::*;

   logic [15:0] iv_normal_ff, iv_low_ff, iv_crit_ff;
   // ms ticks since last send; only the difference of the ms clock and the last send time is observable
   logic [31:0] elapsed_ff, elapsed_in;
   logic [7:0]  pkt_ff, pkt_in;
   logic [15:0] uptime_ff, uptime_in;
   logic        busy_ff, busy_in;

   logic [31:0] elapsed_inc;
   logic [15:0] interval;
   logic        due;

   always_comb begin
      if (power_state == PS_LOW) begin
         interval = iv_low_ff;
      end else if (power_state inside {PS_CRITICAL, PS_ERROR}) begin
         interval = iv_crit_ff;
      end else begin
         interval = iv_normal_ff;
      end
      elapsed_inc = elapsed_ff + 32'd1;
      due = (power_state != PS_HIBERNATE) && (elapsed_inc >= {16'd0, interval});
   end

   always_comb begin
      elapsed_in = elapsed_ff;
      pkt_in     = pkt_ff;
      uptime_in  = uptime_ff;
      busy_in    = busy_ff;
      push       = 1'b0;
      if (req_fire) begin
         case (kind)
            KIND_MS_TICK: begin
               elapsed_in = due ? 32'd0 : elapsed_inc;
               if (due) begin
                  pkt_in = pkt_ff + 8'd1;
                  push   = !busy_ff;
               end
            end
            KIND_SEC_TICK: begin
               uptime_in = uptime_ff + 16'd1;
            end
            KIND_SEND_NOW: begin
               if (!busy_ff) begin
                  elapsed_in = 32'd0;
                  pkt_in     = pkt_ff + 8'd1;
                  push       = 1'b1;
               end
            end
            KIND_TX_DONE: begin
               busy_in = 1'b0;
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
         if (push) begin
            busy_in = 1'b1;
         end
      end
   end

   always_comb begin
      push_desc.pkt_id             = pkt_ff;
      push_desc.power_state        = power_state;
      push_desc.charge_percent     = charge_percent;
      push_desc.boot_cause         = boot_cause;
      push_desc.battery_centivolts = battery_centivolts;
      push_desc.solar_centivolts   = solar_centivolts;
      push_desc.status_bits        = status_bits;
      push_desc.load_bits          = load_bits;
      push_desc.uptime             = uptime_ff;
      push_desc.checksum = SYNC_BYTE_0 ^ SYNC_BYTE_1 ^ pkt_ff ^ {5'd0, power_state}
         ^ {1'b0, charge_percent} ^ {6'd0, boot_cause}
         ^ battery_centivolts[15:8] ^ battery_centivolts[7:0]
         ^ solar_centivolts[15:8] ^ solar_centivolts[7:0]
         ^ {5'd0, status_bits} ^ {5'd0, load_bits}
         ^ uptime_ff[7:0] ^ uptime_ff[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         pkt_ff     <= '0;
         uptime_ff  <= '0;
         busy_ff    <= 1'b0;
      end else begin
         elapsed_ff <= elapsed_in;
         pkt_ff     <= pkt_in;
         uptime_ff  <= uptime_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_normal_ff <= INTERVAL_NORMAL_RESET;
         iv_low_ff    <= INTERVAL_LOW_POWER_RESET;
         iv_crit_ff   <= INTERVAL_CRITICAL_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            REG_INTERVAL_NORMAL:    iv_normal_ff <= csr_data;
            REG_INTERVAL_LOW_POWER: iv_low_ff    <= csr_data;
            REG_INTERVAL_CRITICAL:  iv_crit_ff   <= csr_data;
            default:                iv_normal_ff <= iv_normal_ff;
         endcase
      end
   end

   `TFS_ASSERT(a_push_sets_busy, push |=> busy_ff, "frame pushed without busy set")
   `TFS_ASSERT(a_no_push_busy, busy_ff |-> !push, "frame pushed while transmitter busy")

endmodule

@@ rtl/core/tfs_back.sv @@
// Back end: pops frame descriptors and streams the 16 frame bytes.
// Depends on tfs_pkg.
module tfs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tfs_pkg::frame_desc_type head_desc,
   input  tfs_pkg::queue_stat_type stat,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);
   import tfs_pkg::*;

   back_state_type state_ff, state_in;
   logic [3:0]     cnt_ff, cnt_in;
   frame_desc_type desc_ff;
   logic           rsp_fire;
   logic           last;

   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign last     = (cnt_ff == FRAME_LAST);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pop      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!stat.empty) begin
               pop      = 1'b1;
               cnt_in   = '0;
               state_in = BK_SEND;
            end
         end
         BK_SEND: begin
            if (rsp_fire) begin
               if (last) begin
                  cnt_in = '0;
                  if (stat.empty) begin
                     state_in = BK_IDLE;
                  end else begin
                     pop = 1'b1;
                  end
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         desc_ff <= head_desc;
      end
   end

   always_comb begin
      case (cnt_ff)
         4'd0:    rsp_tdata = SYNC_BYTE_0;
         4'd1:    rsp_tdata = SYNC_BYTE_1;
         4'd2:    rsp_tdata = desc_ff.pkt_id;
         4'd3:    rsp_tdata = {5'd0, desc_ff.power_state};
         4'd4:    rsp_tdata = {1'b0, desc_ff.charge_percent};
         4'd5:    rsp_tdata = {6'd0, desc_ff.boot_cause};
         4'd6:    rsp_tdata = desc_ff.battery_centivolts[15:8];
         4'd7:    rsp_tdata = desc_ff.battery_centivolts[7:0];
         4'd8:    rsp_tdata = desc_ff.solar_centivolts[15:8];
         4'd9:    rsp_tdata = desc_ff.solar_centivolts[7:0];
         4'd10:   rsp_tdata = {5'd0, desc_ff.status_bits};
         4'd11:   rsp_tdata = {5'd0, desc_ff.load_bits};
         4'd12:   rsp_tdata = desc_ff.uptime[7:0];
         4'd13:   rsp_tdata = desc_ff.uptime[15:8];
         4'd14:   rsp_tdata = desc_ff.checksum;
         default: rsp_tdata = STOP_BYTE;
      endcase
   end

   assign rsp_tvalid = (state_ff == BK_SEND);
   assign rsp_tlast  = last;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for telemetry_frame_scheduler_top.
// Depends on tfs_pkg and the scheduler RTL. A directed table runs first, then random traffic.
module tb;
   import tfs_pkg::*;

   localparam logic [2:0] PS_BOOT        = 3'd0;
   localparam logic [2:0] PS_POWER_CHECK = 3'd1;
   localparam logic [2:0] PS_CHARGING    = 3'd2;
   localparam logic [2:0] PS_NORMAL      = 3'd3;

   localparam int FRAME_BYTES     = 16;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 48;

   // normal, low power, critical interval per random phase
   localparam logic [15:0] PHASE_IV [PHASES][3] = '{
      '{16'd3,     16'd5,     16'd7},
      '{16'd1,     16'd65535, 16'd0},
      '{16'd2,     16'd1,     16'd4},
      '{16'd6,     16'd9,     16'd2},
      '{16'd65535, 16'd2,     16'd1},
      '{16'd4,     16'd3,     16'd2}
   };

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  power_state;
      logic [6:0]  charge_percent;
      logic [1:0]  boot_cause;
      logic [15:0] battery_cv;
      logic [15:0] solar_cv;
      logic [2:0]  status_bits;
      logic [2:0]  load_bits;
   } telemetry_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_beat_type;

   typedef enum logic [1:0] {
      OUT_MODEL,
      OUT_NONE,
      OUT_BLANK
   } outcome_type;

   typedef struct {
      logic               is_cfg;
      logic [1:0]         reg_idx;
      logic [15:0]        reg_value;
      telemetry_item_type item;
      outcome_type        outcome;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   telemetry_frame_scheduler_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scheduler shadow state and interval registers
   logic [31:0] ms_clock, last_send, uptime;
   logic [7:0]  pkt_count;
   logic        tx_busy;
   logic [15:0] iv_normal, iv_low, iv_critical;

   frame_beat_type     frame_beats_due[$];
   frame_beat_type     want;
   directed_row_type   directed_rows[$];
   int                 fail_count = 0;
   int                 beats_checked = 0;
   int                 items_sent = 0;
   int                 cycle_count = 0;
   int                 send_gap_pct = 17;
   int                 recv_gap_pct = 55;

   function automatic directed_row_type stim(logic [1:0] kind, logic [2:0] ps,
                                             logic [6:0] charge, logic [1:0] boot,
                                             logic [15:0] bat, logic [15:0] sol,
                                             logic [2:0] status, logic [2:0] load,
                                             outcome_type oc);
      directed_row_type r;
      r.is_cfg = 1'b0;
      r.reg_idx = '0;
      r.reg_value = '0;
      r.item = '{kind, ps, charge, boot, bat, sol, status, load};
      r.outcome = oc;
      return r;
   endfunction

   function automatic directed_row_type cfg(logic [1:0] idx, logic [15:0] value);
      directed_row_type r;
      r.is_cfg = 1'b1;
      r.reg_idx = idx;
      r.reg_value = value;
      r.item = '0;
      r.outcome = OUT_NONE;
      return r;
   endfunction

   function automatic telemetry_item_type random_item();
      telemetry_item_type it;
      int pick;
      pick = $urandom_range(99);
      if (tx_busy)
         it.kind = (pick < 45) ? KIND_TX_DONE : (pick < 88) ? KIND_MS_TICK :
                   (pick < 94) ? KIND_SEC_TICK : KIND_SEND_NOW;
      else
         it.kind = (pick < 68) ? KIND_MS_TICK : (pick < 80) ? KIND_SEC_TICK :
                   (pick < 95) ? KIND_SEND_NOW : KIND_TX_DONE;
      it.power_state = 3'($urandom_range(7));
      // mostly in-range snapshots, now and then the full field width
      it.charge_percent = ($urandom_range(19) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(100));
      it.boot_cause = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      pick = $urandom_range(9);
      it.battery_cv = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      pick = $urandom_range(9);
      it.solar_cv = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      it.status_bits = 3'($urandom_range(7));
      it.load_bits = 3'($urandom_range(7));
      return it;
   endfunction

   // Updates the shadow state for one request and returns the frame bytes it produces.
   task automatic advance_scheduler(input telemetry_item_type it,
                                    output frame_beat_type beats[16], output int n);
      logic [15:0] iv;
      logic [31:0] elapsed;
      logic [7:0]  b [16];
      logic [7:0]  x;
      logic        emit, bump;
      emit = 1'b0;
      bump = 1'b0;
      n = 0;
      case (it.kind)
         KIND_MS_TICK: begin
            ms_clock = ms_clock + 32'd1;
            if (it.power_state == PS_LOW)
               iv = iv_low;
            else if (it.power_state == PS_CRITICAL || it.power_state == PS_ERROR)
               iv = iv_critical;
            else
               iv = iv_normal;
            elapsed = ms_clock - last_send;
            if (it.power_state != PS_HIBERNATE && elapsed >= {16'd0, iv}) begin
               last_send = ms_clock;
               emit = !tx_busy;
               bump = 1'b1;
            end
         end
         KIND_SEC_TICK: uptime = uptime + 32'd1;
         KIND_SEND_NOW: begin
            if (!tx_busy) begin
               emit = 1'b1;
               bump = 1'b1;
               last_send = ms_clock;
            end
         end
         default: tx_busy = 1'b0;
      endcase
      if (emit) begin
         b[0] = SYNC_BYTE_0;
         b[1] = SYNC_BYTE_1;
         b[2] = pkt_count;
         b[3] = {5'd0, it.power_state};
         b[4] = {1'b0, it.charge_percent};
         b[5] = {6'd0, it.boot_cause};
         b[6] = it.battery_cv[15:8];
         b[7] = it.battery_cv[7:0];
         b[8] = it.solar_cv[15:8];
         b[9] = it.solar_cv[7:0];
         b[10] = {5'd0, it.status_bits};
         b[11] = {5'd0, it.load_bits};
         b[12] = uptime[7:0];
         b[13] = uptime[15:8];
         x = 8'd0;
         for (int i = 0; i < 14; i++)
            x = x ^ b[i];
         b[14] = x;
         b[15] = STOP_BYTE;
         for (int i = 0; i < FRAME_BYTES; i++)
            beats[i] = '{b[i], (i == FRAME_BYTES - 1)};
         tx_busy = 1'b1;
         n = FRAME_BYTES;
      end
      if (bump)
         pkt_count = pkt_count + 8'd1;
   endtask

   // Entered and left at a falling edge; valid stays high into the next call when no gap follows.
   task automatic send_item(input telemetry_item_type it, input outcome_type oc);
      frame_beat_type beats [16];
      int n;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = it.kind;
      req_tdata = {6'd0, it.load_bits, it.status_bits, it.solar_cv, it.battery_cv,
                   it.boot_cause, it.charge_percent, it.power_state};
      do @(posedge clock); while (!req_tready);
      advance_scheduler(it, beats, n);
      items_sent++;
      if (oc == OUT_MODEL) begin
         for (int i = 0; i < n; i++)
            frame_beats_due.push_back(beats[i]);
      end else if (oc == OUT_BLANK) begin
         // all snapshot fields, id and uptime zero: only sync, checksum and stop are set
         frame_beats_due.push_back('{SYNC_BYTE_0, 1'b0});
         frame_beats_due.push_back('{SYNC_BYTE_1, 1'b0});
         for (int i = 2; i < 14; i++)
            frame_beats_due.push_back('{8'h00, 1'b0});
         frame_beats_due.push_back('{SYNC_BYTE_0 ^ SYNC_BYTE_1, 1'b0});
         frame_beats_due.push_back('{STOP_BYTE, 1'b1});
      end
      @(negedge clock);
   endtask

   task automatic drain_and_settle(input int cycles);
      req_tvalid = 1'b0;
      while (frame_beats_due.size() != 0)
         @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic write_interval(input logic [1:0] idx, input logic [15:0] value);
      drain_and_settle(SETTLE_CYCLES);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_INTERVAL_NORMAL:    iv_normal = value;
         REG_INTERVAL_LOW_POWER: iv_low = value;
         default:                iv_critical = value;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_gap_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_beats_due.size() == 0) begin
            $display("%0t: unexpected frame byte transaction, expected none, actual %02h last %0b",
                     $time, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = frame_beats_due.pop_front();
            if (rsp_tdata !== want.data) begin
               $display("%0t: frame byte mismatch, expected %02h, actual %02h",
                        $time, want.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: frame end mismatch, expected %0b, actual %0b",
                        $time, want.last, rsp_tlast);
               fail_count++;
            end
            beats_checked++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout at %0t with %0d frame bytes outstanding", $time, frame_beats_due.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      ms_clock = '0;
      last_send = '0;
      uptime = '0;
      pkt_count = '0;
      tx_busy = 1'b0;
      iv_normal = INTERVAL_NORMAL_RESET;
      iv_low = INTERVAL_LOW_POWER_RESET;
      iv_critical = INTERVAL_CRITICAL_RESET;

      // reset defaults: send now, ignored send while busy, non-due tick
      directed_rows.push_back(stim(KIND_SEND_NOW, PS_BOOT, 7'd0, 2'd0, 16'h0000, 16'h0000,
                                   3'd0, 3'd0, OUT_BLANK));
      directed_rows.push_back(stim(KIND_SEND_NOW, PS_ERROR, 7'd127, 2'd3, 16'hFFFF, 16'hFFFF,
                                   3'd7, 3'd7, OUT_NONE));
      directed_rows.push_back(stim(KIND_MS_TICK, PS_NORMAL, 7'd50, 2'd1, 16'd370, 16'd512,
                                   3'd1, 3'd1, OUT_NONE));
      directed_rows.push_back(stim(KIND_SEC_TICK, PS_NORMAL, 7'd50, 2'd1, 16'd370, 16'd512,
                                   3'd1, 3'd1, OUT_NONE));
      directed_rows.push_back(stim(KIND_TX_DONE, PS_NORMAL, 7'd50, 2'd1, 16'd370, 16'd512,
                                   3'd1, 3'd1, OUT_NONE));
      directed_rows.push_back(stim(KIND_SEND_NOW, PS_ERROR, 7'd127, 2'd3, 16'hFFFF, 16'hFFFF,
                                   3'd7, 3'd7, OUT_MODEL));
      directed_rows.push_back(stim(KIND_TX_DONE, PS_BOOT, 7'd0, 2'd0, 16'h0000, 16'h0000,
                                   3'd0, 3'd0, OUT_NONE));
      // zero interval: every tick is due, also while busy, but not in hibernate
      directed_rows.push_back(cfg(REG_INTERVAL_NORMAL, 16'd0));
      directed_rows.push_back(stim(KIND_MS_TICK, PS_BOOT, 7'd100, 2'd2, 16'h1234, 16'hABCD,
                                   3'd5, 3'd2, OUT_MODEL));
      directed_rows.push_back(stim(KIND_MS_TICK, PS_POWER_CHECK, 7'd99, 2'd0, 16'h0401,
                                   16'h0802, 3'd2, 3'd5, OUT_NONE));
      directed_rows.push_back(stim(KIND_TX_DONE, PS_POWER_CHECK, 7'd99, 2'd0, 16'h0401,
                                   16'h0802, 3'd2, 3'd5, OUT_NONE));
      directed_rows.push_back(stim(KIND_MS_TICK, PS_HIBERNATE, 7'd12, 2'd1, 16'd300, 16'd0,
                                   3'd0, 3'd0, OUT_NONE));
      directed_rows.push_back(stim(KIND_MS_TICK, PS_CHARGING, 7'd64, 2'd1, 16'h8000, 16'h7FFF,
                                   3'd1, 3'd4, OUT_MODEL));
      directed_rows.push_back(stim(KIND_TX_DONE, PS_CHARGING, 7'd64, 2'd1, 16'h8000, 16'h7FFF,
                                   3'd1, 3'd4, OUT_NONE));
      // long critical period: neither critical nor error state is due yet
      directed_rows.push_back(cfg(REG_INTERVAL_CRITICAL, 16'd65535));
      directed_rows.push_back(stim(KIND_MS_TICK, PS_CRITICAL, 7'd5, 2'd0, 16'd310, 16'd0,
                                   3'd2, 3'd0, OUT_NONE));
      directed_rows.push_back(stim(KIND_MS_TICK, PS_ERROR, 7'd3, 2'd2, 16'd305, 16'd0,
                                   3'd2, 3'd0, OUT_NONE));
      directed_rows.push_back(cfg(REG_INTERVAL_LOW_POWER, 16'd1));
      directed_rows.push_back(stim(KIND_MS_TICK, PS_LOW, 7'd20, 2'd0, 16'd340, 16'd1850,
                                   3'd0, 3'd3, OUT_MODEL));
      directed_rows.push_back(stim(KIND_TX_DONE, PS_LOW, 7'd20, 2'd0, 16'd340, 16'd1850,
                                   3'd0, 3'd3, OUT_NONE));
      directed_rows.push_back(stim(KIND_SEC_TICK, PS_LOW, 7'd20, 2'd0, 16'd340, 16'd1850,
                                   3'd0, 3'd3, OUT_NONE));
      directed_rows.push_back(cfg(REG_INTERVAL_NORMAL, 16'd65535));
      directed_rows.push_back(stim(KIND_MS_TICK, PS_NORMAL, 7'd80, 2'd0, 16'd400, 16'd2000,
                                   3'd4, 3'd1, OUT_NONE));
      directed_rows.push_back(stim(KIND_SEND_NOW, PS_LOW, 7'd0, 2'd0, 16'h00FF, 16'hFF00,
                                   3'd6, 3'd6, OUT_MODEL));
      directed_rows.push_back(stim(KIND_TX_DONE, PS_LOW, 7'd0, 2'd0, 16'h00FF, 16'hFF00,
                                   3'd6, 3'd6, OUT_NONE));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg)
            write_interval(directed_rows[i].reg_idx, directed_rows[i].reg_value);
         else
            send_item(directed_rows[i].item, directed_rows[i].outcome);
      end

      for (int p = 0; p < PHASES; p++) begin
         send_gap_pct = (p < 2) ? 17 : (p < 4) ? 55 : 0;
         recv_gap_pct = (p < 2) ? 55 : (p < 4) ? 17 : 0;
         write_interval(REG_INTERVAL_NORMAL, PHASE_IV[p][0]);
         write_interval(REG_INTERVAL_LOW_POWER, PHASE_IV[p][1]);
         write_interval(REG_INTERVAL_CRITICAL, PHASE_IV[p][2]);
         for (int k = 0; k < ITEMS_PER_PHASE; k++)
            send_item(random_item(), OUT_MODEL);
      end

      drain_and_settle(TAIL_CYCLES);
      $display("Sent %0d request transactions, checked %0d frame bytes (%0d frames)",
               items_sent, beats_checked, beats_checked / FRAME_BYTES);
      $display("Intervals swept over reset defaults, zero, one, 65535 and %0d random phases",
               PHASES);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
